FILE: design/tlpt_pkg.sv
// Shared types and constants for the two-level page table unit.
package tlpt_pkg;

  localparam int OFFSET_BITS = 12;
  localparam int VPN_W       = 20;
  localparam int FRAME_W     = 20;
  localparam int PAGES_W     = 21;
  localparam int ADDR_W      = 32;
  localparam int CNT_W       = 32;
  // base page plus page count, wide enough to hold the sum
  localparam int SPAN_W      = 22;
  localparam logic [CNT_W-1:0] ACCESS_STEP = 32'd2;

  typedef enum logic [1:0] {
    CMD_MAP           = 2'd0,
    CMD_TRANSLATE     = 2'd1,
    CMD_FREE          = 2'd2,
    CMD_CLEAR_PRESENT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_INVALID     = 2'd1,
    STAT_NOT_PRESENT = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [VPN_W-1:0]   page_number;
    logic [FRAME_W-1:0] frame_number;
    logic [PAGES_W-1:0] page_count;
    logic [ADDR_W-1:0]  virt_addr;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [VPN_W-1:0]   entry_page;
    logic [FRAME_W-1:0] entry_frame;
    logic [PAGES_W-1:0] entry_pages;
    logic [CNT_W-1:0]   access_total;
  } out_item_t;

  // one page table entry, 63 bits
  typedef struct packed {
    logic               present;
    logic               valid;
    logic [PAGES_W-1:0] pages;
    logic [FRAME_W-1:0] frame;
    logic [VPN_W-1:0]   page;
  } entry_t;

  // table read address source
  typedef enum logic [1:0] {
    RD_VPN,
    RD_BASE,
    RD_IDX
  } rd_sel_t;

  // table write data source
  typedef enum logic [1:0] {
    WR_INIT,
    WR_MAP,
    WR_ZERO,
    WR_CLRP
  } wr_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    init_map;
    logic    init_walk;
    logic    idx_inc;
    logic    res_load;
    logic    out_load;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t op;
    logic map_skip;
    logic base_out;
    logic base_ok;
    logic walk_last;
    logic clr_last;
    logic out_free;
  } ctl_status_t;

endpackage

FILE: design/tlpt_ctrl.sv
// Sequencer for the page table unit: clearing pass, command dispatch and walks.
module tlpt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tlpt_pkg::ctl_status_t st_i,
  output tlpt_pkg::ctl_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_MAP_WR,
    ST_TR_WAIT,
    ST_BASE_WAIT,
    ST_FREE_WR,
    ST_CLR_RD,
    ST_CLR_WR,
    ST_RESP
  } state_t;

  state_t state_r, state_nxt;

  // items are taken only when the sequencer is idle
  assign in_stall = (state_r != ST_IDLE);

  // next state and datapath commands
  always_comb begin
    state_nxt        = state_r;
    cmd_o.capture    = 1'b0;
    cmd_o.rd_en      = 1'b0;
    cmd_o.rd_sel     = tlpt_pkg::RD_IDX;
    cmd_o.wr_en      = 1'b0;
    cmd_o.wr_sel     = tlpt_pkg::WR_ZERO;
    cmd_o.init_map   = 1'b0;
    cmd_o.init_walk  = 1'b0;
    cmd_o.idx_inc    = 1'b0;
    cmd_o.res_load   = 1'b0;
    cmd_o.out_load   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = tlpt_pkg::WR_INIT;
        cmd_o.idx_inc = 1'b1;
        if (st_i.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_nxt     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (st_i.op)
          tlpt_pkg::CMD_MAP: begin
            if (st_i.map_skip) begin
              cmd_o.res_load = 1'b1;
              state_nxt      = ST_RESP;
            end else begin
              cmd_o.init_map = 1'b1;
              state_nxt      = ST_MAP_WR;
            end
          end
          tlpt_pkg::CMD_TRANSLATE: begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = tlpt_pkg::RD_VPN;
            state_nxt    = ST_TR_WAIT;
          end
          tlpt_pkg::CMD_FREE, tlpt_pkg::CMD_CLEAR_PRESENT: begin
            if (st_i.base_out) begin
              cmd_o.res_load = 1'b1;
              state_nxt      = ST_RESP;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = tlpt_pkg::RD_BASE;
              state_nxt    = ST_BASE_WAIT;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_MAP_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = tlpt_pkg::WR_MAP;
        cmd_o.idx_inc = 1'b1;
        if (st_i.walk_last) begin
          cmd_o.res_load = 1'b1;
          state_nxt      = ST_RESP;
        end
      end
      ST_TR_WAIT: begin
        cmd_o.res_load = 1'b1;
        state_nxt      = ST_RESP;
      end
      ST_BASE_WAIT: begin
        if (!st_i.base_ok) begin
          cmd_o.res_load = 1'b1;
          state_nxt      = ST_RESP;
        end else begin
          cmd_o.init_walk = 1'b1;
          state_nxt = (st_i.op == tlpt_pkg::CMD_FREE) ? ST_FREE_WR : ST_CLR_RD;
        end
      end
      ST_FREE_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = tlpt_pkg::WR_ZERO;
        cmd_o.idx_inc = 1'b1;
        if (st_i.walk_last) begin
          cmd_o.res_load = 1'b1;
          state_nxt      = ST_RESP;
        end
      end
      ST_CLR_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = tlpt_pkg::RD_IDX;
        state_nxt    = ST_CLR_WR;
      end
      ST_CLR_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = tlpt_pkg::WR_CLRP;
        cmd_o.idx_inc = 1'b1;
        if (st_i.walk_last) begin
          cmd_o.res_load = 1'b1;
          state_nxt      = ST_RESP;
        end else begin
          state_nxt = ST_CLR_RD;
        end
      end
      ST_RESP: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a table read and a table write never share a cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_o.rd_en && cmd_o.wr_en))
    else $error("table read and write in the same cycle");

  // a staged result is always followed by the response state
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.res_load |=> state_r == ST_RESP)
    else $error("staged result not followed by response");

  // the clearing pass finishes before any item is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.capture |-> !(cmd_o.wr_en && cmd_o.wr_sel == tlpt_pkg::WR_INIT))
    else $error("item taken during clearing pass");

endmodule

FILE: design/tlpt_datapath.sv
// Page table storage, walk index, access counter and result registers.
module tlpt_datapath #(
  parameter int TABLE_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tlpt_pkg::in_item_t    in_item,
  input  tlpt_pkg::ctl_cmd_t    cmd_i,
  output tlpt_pkg::ctl_status_t st_o,
  input  logic                  out_stall,
  output logic                  out_valid,
  output tlpt_pkg::out_item_t   out_item
);

  localparam int Depth = 1 << TABLE_BITS;
  localparam logic [TABLE_BITS:0] TableEnd = {1'b1, {TABLE_BITS{1'b0}}};
  localparam logic [tlpt_pkg::SPAN_W-1:0] SpanLimit = tlpt_pkg::SPAN_W'(TableEnd);

  // captured item
  tlpt_pkg::cmd_t                  op_r;
  logic [tlpt_pkg::VPN_W-1:0]      base_r;
  logic [tlpt_pkg::FRAME_W-1:0]    frame_r;
  logic [tlpt_pkg::PAGES_W-1:0]    count_r;
  logic [tlpt_pkg::VPN_W-1:0]      vpn_r;

  // walk state
  logic [TABLE_BITS-1:0]           idx_r, idx_nxt;
  logic [TABLE_BITS:0]             end_r, end_nxt;

  tlpt_pkg::entry_t                store_r [Depth];
  tlpt_pkg::entry_t                rdata_r;
  tlpt_pkg::entry_t                wr_data;
  logic [TABLE_BITS-1:0]           rd_addr;

  logic [tlpt_pkg::CNT_W-1:0]      access_r, access_nxt;
  tlpt_pkg::out_item_t             res_r, res_nxt;
  tlpt_pkg::out_item_t             out_item_r;
  logic                            out_valid_r;

  logic                            vpn_out;
  logic [tlpt_pkg::SPAN_W-1:0]     map_span, walk_span;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      op_r    <= in_item.cmd;
      base_r  <= in_item.page_number;
      frame_r <= in_item.frame_number;
      count_r <= in_item.page_count;
      vpn_r   <= in_item.virt_addr[tlpt_pkg::OFFSET_BITS +: tlpt_pkg::VPN_W];
    end
  end

  // span ends, clipped at the end of the table
  assign map_span  = {2'b00, base_r} + {1'b0, count_r};
  assign walk_span = {2'b00, base_r} + {1'b0, rdata_r.pages};

  always_comb begin
    idx_nxt = idx_r;
    end_nxt = end_r;
    if (cmd_i.init_map) begin
      idx_nxt = base_r[TABLE_BITS-1:0];
      end_nxt = (map_span >= SpanLimit) ? TableEnd : map_span[TABLE_BITS:0];
    end else if (cmd_i.init_walk) begin
      idx_nxt = base_r[TABLE_BITS-1:0];
      end_nxt = (walk_span >= SpanLimit) ? TableEnd : walk_span[TABLE_BITS:0];
    end else if (cmd_i.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      end_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      end_r <= end_nxt;
    end
  end

  // table read address and write data
  always_comb begin
    case (cmd_i.rd_sel)
      tlpt_pkg::RD_VPN:  rd_addr = vpn_r[TABLE_BITS-1:0];
      tlpt_pkg::RD_BASE: rd_addr = base_r[TABLE_BITS-1:0];
      default:           rd_addr = idx_r;
    endcase
  end

  always_comb begin
    wr_data = '0;
    case (cmd_i.wr_sel)
      tlpt_pkg::WR_MAP: begin
        wr_data.present = 1'b1;
        wr_data.valid   = 1'b1;
        wr_data.pages   = count_r;
        wr_data.frame   = frame_r;
        wr_data.page    = base_r;
      end
      tlpt_pkg::WR_CLRP: begin
        wr_data         = rdata_r;
        wr_data.present = 1'b0;
      end
      default: wr_data = '0;
    endcase
  end

  // page table memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd_i.wr_en) store_r[idx_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.rd_en) rdata_r <= store_r[rd_addr];
  end

  // result formation
  assign vpn_out = ({2'b00, vpn_r} >= SpanLimit);

  always_comb begin
    access_nxt = access_r;
    res_nxt    = res_r;
    if (cmd_i.res_load) begin
      res_nxt.status      = tlpt_pkg::STAT_OK;
      res_nxt.entry_page  = '0;
      res_nxt.entry_frame = '0;
      res_nxt.entry_pages = '0;
      if (op_r == tlpt_pkg::CMD_TRANSLATE) begin
        access_nxt = access_r + tlpt_pkg::ACCESS_STEP;
        if (vpn_out || !rdata_r.valid) begin
          res_nxt.status = tlpt_pkg::STAT_INVALID;
        end else begin
          res_nxt.status      = rdata_r.present ? tlpt_pkg::STAT_OK
                                                : tlpt_pkg::STAT_NOT_PRESENT;
          res_nxt.entry_page  = rdata_r.page;
          res_nxt.entry_frame = rdata_r.frame;
          res_nxt.entry_pages = rdata_r.pages;
        end
      end
      res_nxt.access_total = access_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      access_r <= '0;
    end else begin
      access_r <= access_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (cmd_i.out_load) out_item_r <= res_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // status to the controller
  assign st_o.op        = op_r;
  assign st_o.base_out  = ({2'b00, base_r} >= SpanLimit);
  assign st_o.map_skip  = (count_r == '0) || st_o.base_out;
  assign st_o.base_ok   = rdata_r.valid && (rdata_r.pages != '0);
  assign st_o.walk_last = (({1'b0, idx_r} + 1'b1) == end_r);
  assign st_o.clr_last  = (idx_r == {TABLE_BITS{1'b1}});
  assign st_o.out_free  = !out_valid_r || !out_stall;

  // walk writes stay inside the span
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.wr_en && cmd_i.wr_sel != tlpt_pkg::WR_INIT |-> ({1'b0, idx_r} < end_r))
    else $error("table write past end of span");

  // counter moves only on a translate result
  assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_i.res_load && op_r == tlpt_pkg::CMD_TRANSLATE) |=> $stable(access_r))
    else $error("access counter changed outside translate");

  // a result never overwrites one that is still held
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.out_load |-> (!out_valid_r || !out_stall))
    else $error("held result overwritten");

endmodule

FILE: design/two_level_page_table_unit.sv
// Two-level page table unit: one entry per 4 KiB page, indexed by DIR_BITS +
// ENTRY_BITS bits of virtual page number, held in a single-port-write,
// registered-read table memory. After reset a clearing pass writes every entry
// invalid, one a cycle; no item is accepted meanwhile. One item is handled at
// a time and each gives one result. Translate passes dispatch, table read,
// result stage and output load; map writes its span one table write a cycle,
// and free does the same after reading the base entry; clear-present reads
// the base entry and then does a read followed by a write for each page.
// Spans stop at the last entry of the table. A new item is accepted while the
// previous result is still waiting in the output register.
module two_level_page_table_unit #(
  parameter int DIR_BITS   = 10,
  parameter int ENTRY_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tlpt_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tlpt_pkg::out_item_t out_item
);

  localparam int TableBits = DIR_BITS + ENTRY_BITS;

  tlpt_pkg::ctl_cmd_t    cmd;
  tlpt_pkg::ctl_status_t st;

  tlpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st_i     (st),
    .cmd_o    (cmd)
  );

  tlpt_datapath #(
    .TABLE_BITS (TableBits)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd_i     (cmd),
    .st_o      (st),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
